// ===== rtl/mandelbrot_escape_count_defines.svh =====
// Assertion macros for the escape-count block and its checker.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef MANDELBROT_ESCAPE_COUNT_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mec_pkg.sv =====
// Shared types and constants of the escape-count block.
// Used by the controller, the datapath, the top level and the checker.
package mec_pkg;

  // Default parameter values.
  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_WIDTH_DEF = 12;

  // Fixed field and port widths.
  localparam int COORD_W = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Register reset value and escape radius squared.
  localparam int DEFAULT_LIMIT    = 511;
  localparam int ESCAPE_RADIUS_SQ = 4;

  // Register index of the iteration limit (word index within paddr).
  localparam logic [ADDR_W-3:0] IDX_ITER_LIMIT = '0;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CHK  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take c, set z = c and count = 0
    logic mul;    // form x*x, y*y and x*y
    logic step;   // store z^2 + c and count one iteration
    logic push;   // copy the count into the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lim_zero;   // iteration limit is zero
    logic escape;     // |z|^2 has reached the escape radius squared
    logic last;       // the pending step reaches the iteration limit
  } dp_status_t;

endpackage

// ===== rtl/mec_ctrl.sv =====
// Controller of the escape-count block: sequences load, multiply, check and
// result hand-off. Uses mec_pkg for the state and command types.
module mec_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  mec_pkg::dp_status_t   status,
  output mec_pkg::ctrl_cmd_t    cmd
);

  mec_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      mec_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.lim_zero ? mec_pkg::S_DONE : mec_pkg::S_MUL;
        end
      end
      mec_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mec_pkg::S_CHK;
      end
      mec_pkg::S_CHK: begin
        if (status.escape) begin
          state_nxt = mec_pkg::S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = status.last ? mec_pkg::S_DONE : mec_pkg::S_MUL;
        end
      end
      mec_pkg::S_DONE: begin
        // Hand the count over once the result register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.push  = 1'b1;
          state_nxt = mec_pkg::S_IDLE;
        end
      end
      default: state_nxt = mec_pkg::S_IDLE;
    endcase
  end

  // The result register stays full until the item is taken.
  assign out_valid_nxt = cmd.push | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mec_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != mec_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/mec_dp.sv =====
// Datapath of the escape-count block: z registers, the three multipliers,
// the z^2 + c update with saturation, the escape test and the counter.
// Uses mec_pkg for the command and status types.
module mec_dp #(
  parameter int FRAC_BITS   = mec_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = mec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  mec_pkg::ctrl_cmd_t                  cmd,
  input  logic signed [mec_pkg::COORD_W-1:0]  c_real,
  input  logic signed [mec_pkg::COORD_W-1:0]  c_imag,
  input  logic [COUNT_WIDTH-1:0]              limit,
  output mec_pkg::dp_status_t                 status,
  output logic [COUNT_WIDTH-1:0]              iteration_count
);

  localparam int CW    = mec_pkg::COORD_W;
  localparam int PW    = 2 * CW;
  // Wide enough for a product difference plus c aligned to the product scale.
  localparam int SUMW  = (((CW - 1 + FRAC_BITS) > (PW - 1)) ?
                          (CW - 1 + FRAC_BITS) : (PW - 1)) + 2;
  // Escape is only possible when 4 fits at full product width.
  localparam bit ESC_EN = ((2 * FRAC_BITS + 2) < PW);
  localparam logic [PW-1:0] ESC_THR =
    ESC_EN ? (PW'(mec_pkg::ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS)) : '0;

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0]    x_r, y_r, cx_r, cy_r;
  logic signed [PW-1:0]    xx_r, yy_r, xy_r;
  logic [COUNT_WIDTH-1:0]  count_r, out_count_r;
  logic [COUNT_WIDTH-1:0]  count_inc;

  logic signed [SUMW-1:0]  sum_re, sum_im, sh_re, sh_im;
  logic signed [CW-1:0]    x_nxt, y_nxt;
  logic [PW-1:0]           mag;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
    logic [SUMW-CW:0] top;
    top = v[SUMW-1:CW-1];
    if ((&top) || !(|top)) begin
      sat_coord = v[CW-1:0];
    end else begin
      sat_coord = v[SUMW-1] ? SAT_MIN : SAT_MAX;
    end
  endfunction

  // New z: c is added at product scale, so one floor shift gives the
  // same result as shifting the product first and adding c after.
  assign sum_re = SUMW'(xx_r) - SUMW'(yy_r) + (SUMW'(cx_r) <<< FRAC_BITS);
  assign sum_im = SUMW'(xy_r) + (SUMW'(cy_r) <<< (FRAC_BITS - 1));
  assign sh_re  = sum_re >>> FRAC_BITS;
  assign sh_im  = sum_im >>> (FRAC_BITS - 1);
  assign x_nxt  = sat_coord(sh_re);
  assign y_nxt  = sat_coord(sh_im);

  // Magnitude at full width; both squares are non-negative and at most 2^62.
  assign mag       = $unsigned(xx_r) + $unsigned(yy_r);
  assign count_inc = count_r + COUNT_WIDTH'(1);

  assign status.lim_zero = (limit == '0);
  assign status.escape   = ESC_EN && (mag >= ESC_THR);
  assign status.last     = (count_inc == limit);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= c_real;
      y_r     <= c_imag;
      cx_r    <= c_real;
      cy_r    <= c_imag;
      count_r <= '0;
    end else if (cmd.step) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      count_r <= count_inc;
    end
    if (cmd.mul) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      xy_r <= x_r * y_r;
    end
    if (cmd.push) begin
      out_count_r <= count_r;
    end
  end

  assign iteration_count = out_count_r;

endmodule

// ===== rtl/mandelbrot_escape_count.sv =====
// Top level of the escape-count block: configuration registers, controller
// and datapath. Uses mec_pkg, mec_ctrl and mec_dp.
//
// One point c is taken per item and one iteration count is returned. Each
// iteration of z = z^2 + c first runs through the three 32x32 multipliers,
// then through the update adders and the escape compare. The next point is
// accepted in the cycle after the result is handed to the output register,
// even while that result is still waiting. The iteration limit is written
// at byte address 0 of the APB port.
module mandelbrot_escape_count #(
  parameter int FRAC_BITS   = mec_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = mec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mec_pkg::COORD_W-1:0]  in_c_real,
  input  logic signed [mec_pkg::COORD_W-1:0]  in_c_imag,
  // Result items.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [COUNT_WIDTH-1:0]              out_iteration_count,
  // Configuration.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mec_pkg::ADDR_W-1:0]          paddr,
  input  logic [mec_pkg::DATA_W-1:0]          pwdata,
  output logic [mec_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  logic [COUNT_WIDTH-1:0] limit_r, limit_nxt;
  logic                   sel_limit;
  mec_pkg::ctrl_cmd_t     cmd;
  mec_pkg::dp_status_t    status;

  // Register decode on the word address.
  assign sel_limit = (paddr[mec_pkg::ADDR_W-1:2] == mec_pkg::IDX_ITER_LIMIT);
  assign pready    = 1'b1;
  assign prdata    = sel_limit ? mec_pkg::DATA_W'(limit_r) : '0;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && pready && sel_limit) begin
      limit_nxt = pwdata[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= COUNT_WIDTH'(mec_pkg::DEFAULT_LIMIT);
    end else begin
      limit_r <= limit_nxt;
    end
  end

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mec_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .c_real          (in_c_real),
    .c_imag          (in_c_imag),
    .limit           (limit_r),
    .status          (status),
    .iteration_count (out_iteration_count)
  );

endmodule

// ===== rtl/mec_checker.sv =====
// Port-level checker for the escape-count block, bound to its top level.
// Uses the assertion macros of mandelbrot_escape_count_defines.svh.
`include "mandelbrot_escape_count_defines.svh"

module mec_checker #(
  parameter int COUNT_WIDTH = mec_pkg::COUNT_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COUNT_WIDTH-1:0] out_iteration_count
);

  logic in_take, out_wait, out_take_idle, idle_empty;

  // Handshake terms used by the properties below.
  assign in_take       = in_valid && !in_stall;
  assign out_wait      = out_valid && out_stall;
  assign out_take_idle = out_valid && !out_stall && !in_stall;
  assign idle_empty    = !in_stall && !out_valid;

  // A waiting result holds its count.
  `MEC_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_iteration_count), "count moved")

  // Once an item is accepted the block works on it and takes no other.
  `MEC_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "item accepted while busy")

  // A result taken while the block is idle is not followed at once by another one.
  `MEC_ASSERT_NEXT(a_single_result, out_take_idle, !out_valid, "result repeated")

  // A new item cannot already be waiting in the result register while idle and empty.
  `MEC_ASSERT_SAME(a_idle_taken, !in_stall && $past(idle_empty), !out_valid, "result without item")

endmodule

bind mandelbrot_escape_count mec_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_mec_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_iteration_count (out_iteration_count)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the Mandelbrot escape-count block.
// Drives points and limit writes and checks each count against a local predictor.
// Depends on mec_pkg and the mandelbrot_escape_count top level.
`timescale 1ns / 1ps

module testbench;

  localparam int CNT_W = mec_pkg::COUNT_WIDTH_DEF;
  localparam int FRAC  = mec_pkg::FRAC_BITS_DEF;
  localparam int W     = mec_pkg::COORD_W;
  localparam int AW    = mec_pkg::ADDR_W;

  // Byte addresses of the limit register and of an unused word.
  localparam logic [AW-1:0] ADDR_LIMIT = {mec_pkg::IDX_ITER_LIMIT, 2'b00};
  localparam logic [AW-1:0] ADDR_SPARE = {~mec_pkg::IDX_ITER_LIMIT, 2'b00};

  // |z|^2 at full product width against the escape radius squared.
  localparam logic [63:0] ESCAPE_LEVEL = 64'(mec_pkg::ESCAPE_RADIUS_SQ) << (2 * FRAC);

  // Handy coordinates in Q4.28.
  localparam logic signed [W-1:0] ONE     = 32'sh1000_0000;
  localparam logic signed [W-1:0] TWO     = 32'sh2000_0000;
  localparam logic signed [W-1:0] QUARTER = 32'sh0400_0000;
  localparam logic signed [W-1:0] MAXV    = 32'sh7FFF_FFFF;
  localparam logic signed [W-1:0] MINV    = 32'sh8000_0000;

  // Cycles without any accepted item or register access before giving up.
  localparam int QUIET_LIMIT = 50000;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic signed [W-1:0]  in_c_real   = '0;
  logic signed [W-1:0]  in_c_imag   = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [CNT_W-1:0]     out_iteration_count;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AW-1:0]        paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  logic [CNT_W-1:0]     iter_limit  = CNT_W'(mec_pkg::DEFAULT_LIMIT);
  logic [CNT_W-1:0]     count_expected[$];
  logic [CNT_W-1:0]     count_front;
  logic                 gaps_on     = 1'b1;
  int                   mismatch_cnt = 0;
  int                   quiet_cycles = 0;

  mandelbrot_escape_count u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a value to the signed 32-bit range.
  function automatic longint clamp32(input longint v);
    if (v > longint'(MAXV)) return longint'(MAXV);
    if (v < longint'(MINV)) return longint'(MINV);
    return v;
  endfunction

  // Iterations of z = z^2 + c from z = c until escape or the limit.
  function automatic logic [CNT_W-1:0] escape_count(input logic signed [W-1:0] cr,
                                                    input logic signed [W-1:0] ci,
                                                    input logic [CNT_W-1:0] lim);
    longint zr, zi, rr, ii, ri, nr, ni;
    logic [63:0] mag;
    logic [CNT_W-1:0] n;
    zr = cr;
    zi = ci;
    n  = '0;
    while (n < lim) begin
      rr  = zr * zr;
      ii  = zi * zi;
      ri  = zr * zi;
      mag = rr + ii;
      if (mag >= ESCAPE_LEVEL) break;
      nr = clamp32(((rr - ii) >>> FRAC) + longint'(cr));
      ni = clamp32((ri >>> (FRAC - 1)) + longint'(ci));
      zr = nr;
      zi = ni;
      n++;
    end
    return n;
  endfunction

  // Report the first few mismatches in full and count the rest.
  task automatic log_mismatch(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %0d (%s): expected %0d, got %0d", mismatch_cnt, what, want, got);
  endtask

  // Receiver: stall now and then while gaps are enabled.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 12);
  end

  // Compare every accepted count with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (count_expected.size() == 0) begin
        log_mismatch("unexpected count", 'x, out_iteration_count);
      end else begin
        count_front = count_expected.pop_front();
        if (out_iteration_count !== count_front)
          log_mismatch("iteration count", count_front, out_iteration_count);
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[mandelbrot_escape_count] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one point, record its predicted count and wait until it is taken.
  task automatic send_point(input logic signed [W-1:0] cr, input logic signed [W-1:0] ci);
    if (gaps_on && ($urandom_range(99) < 12)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_c_real <= cr;
    in_c_imag <= ci;
    count_expected.push_back(escape_count(cr, ci, iter_limit));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted count has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (count_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read the limit back and check it.
  task automatic write_register(input logic [AW-1:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_LIMIT) iter_limit = data[CNT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(iter_limit)) log_mismatch("limit readback", 32'(iter_limit), rd);
  endtask

  // Idle the block and program a new limit.
  task automatic set_limit(input logic [31:0] value);
    settle();
    write_register(ADDR_LIMIT, value);
  endtask

  // Random point: mostly around the set, some wider, some over the whole range.
  task automatic random_point(output logic signed [W-1:0] cr, output logic signed [W-1:0] ci);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      cr = $urandom_range(32'h3000_0000) - 32'h2400_0000;
      ci = $urandom_range(32'h3000_0000) - 32'h1800_0000;
    end else if (pick < 80) begin
      cr = $urandom_range(32'h4000_0000) - 32'h2000_0000;
      ci = $urandom_range(32'h4000_0000) - 32'h2000_0000;
    end else begin
      cr = $urandom;
      ci = $urandom;
    end
  endtask

  task automatic run_random(input int n);
    logic signed [W-1:0] cr, ci;
    repeat (n) begin
      random_point(cr, ci);
      send_point(cr, ci);
    end
  endtask

  // Reset limit: inside points, exact escape radius, range extremes.
  task automatic test_default_limit();
    send_point('0, '0);
    send_point(-ONE, '0);
    send_point('0, ONE);
    send_point(QUARTER, '0);
    send_point(ONE, '0);
    send_point(TWO, '0);
    send_point(-TWO, '0);
    send_point(TWO - 1, '0);
    send_point('0, -TWO);
    send_point(MAXV, MAXV);
    send_point(MINV, MINV);
    send_point(MAXV, MINV);
    send_point(MINV, MAXV);
    send_point('0, MINV);
    send_point(MAXV, '0);
  endtask

  // Smallest nonzero limit.
  task automatic test_limit_one();
    set_limit(32'd1);
    send_point('0, '0);
    send_point(ONE, '0);
    send_point(TWO, '0);
  endtask

  // Bits above the count width are dropped, which also gives a zero limit.
  task automatic test_wide_register_value();
    set_limit(32'hFFFF_F005);
    send_point('0, '0);
    set_limit(32'h0000_1000);
    send_point('0, '0);
    send_point(MAXV, MAXV);
  endtask

  // A write to an unused address leaves the limit alone.
  task automatic test_unused_address();
    set_limit(32'd9);
    write_register(ADDR_SPARE, 32'h0000_0123);
    send_point('0, '0);
  endtask

  // Largest limit with points that never escape.
  task automatic test_limit_max();
    set_limit(32'd4095);
    send_point('0, '0);
    send_point(-ONE, '0);
  endtask

  // Short limit with gaps on both sides.
  task automatic test_random_gaps();
    set_limit(32'd32);
    gaps_on = 1'b1;
    run_random(400);
  endtask

  // Varied limits with both sides running flat out.
  task automatic test_random_no_gaps();
    gaps_on = 1'b0;
    repeat (6) begin
      set_limit($urandom_range(100, 2));
      run_random(50);
    end
    gaps_on = 1'b1;
  endtask

  // Longer limits that reach deep into the orbit of each point, then a limit of one.
  task automatic test_random_deep();
    set_limit(32'd200);
    run_random(250);
    set_limit(32'd511);
    run_random(150);
    set_limit(32'd4095);
    run_random(6);
    set_limit(32'd1);
    run_random(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limit();
    test_limit_one();
    test_wide_register_value();
    test_unused_address();
    test_limit_max();
    test_random_gaps();
    test_random_no_gaps();
    test_random_deep();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && count_expected.size() == 0) begin
      $display("[mandelbrot_escape_count] OK");
    end else begin
      $display("[mandelbrot_escape_count] ERROR");
    end
    $finish;
  end

endmodule
